@@ sv/sbg_pkg.sv @@
// spectral bin gate: shared constants, opcode and register index codes,
// and the log2 fraction table; no dependencies
package sbg_pkg;

	localparam int BIN_COUNT   = 512;
	localparam int SAMPLE_BITS = 24;

	localparam int BIN_W   = 9;    // bin index field width
	localparam int LIMIT_W = 16;   // q8.8 dB fields
	localparam int ADDR_W  = $clog2(BIN_COUNT);
	localparam int PWR_W   = 2 * SAMPLE_BITS;
	localparam int POS_W   = $clog2(PWR_W);
	localparam int FRAC_W  = 6;
	localparam int LIN_W   = POS_W + 8;
	localparam int DBQ_W   = 18;
	localparam int PROD_W  = LIN_W + DBQ_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [DBQ_W-1:0] DB_PER_LOG2_Q16 = DBQ_W'(197283);

	// full scale correction in q8.8 dB
	localparam int DB_OFFSET = int'((longint'(2 * (SAMPLE_BITS - 1)) * 256
		* longint'(197283) + 32768) >> 16);

	localparam logic signed [LIMIT_W-1:0] ADJUST_RESET = -16'sd9472;

	typedef enum logic {
		OP_WRITE   = 1'b0,
		OP_PROCESS = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATE_ENABLE  = 1'b0,
		CFG_LEVEL_ADJUST = 1'b1
	} cfg_index_t;

	// round(256 * log2(1 + k/64))
	localparam logic [7:0] LOG2_FRAC [64] = '{
		8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
		8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
		8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
		8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
		8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
		8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
		8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
		8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
	};

	// carried alongside the level computation
	typedef struct packed {
		logic                              chk;
		logic signed [SAMPLE_BITS-1:0]     re;
		logic signed [SAMPLE_BITS-1:0]     im;
		logic signed [LIMIT_W-1:0]         lo;
		logic signed [LIMIT_W-1:0]         hi;
	} carry_t;

endpackage

@@ sv/spectral_bin_gate_top.sv @@
// spectral bin gate top level: limit tables, power to dB pipeline, gating
// depends on sbg_pkg
//
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  --------------------------------------
// command   in         start & !busy             opcode, bin_index, bin_real, bin_imag,
//                                                lower_limit_db, upper_limit_db
// result    out        result_valid (one cycle)  out_real, out_imag, was_gated
// config    in         cfg_write                 cfg_index, cfg_data
//
// one transaction per cycle sustained; busy never rises
// a process transaction's result strobe follows its acceptance through the table read,
// square, add, leading-one, fraction table, multiply and scale stages plus the compare and
// output register
// a write transaction updates both limit tables at the acceptance edge and gives no result
// reset clears control and the config registers; the limit tables are not cleared
// the receiver cannot stall, so nothing ever holds the pipeline
module spectral_bin_gate_top (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic                                      opcode,
	input  logic [sbg_pkg::BIN_W-1:0]                 bin_index,
	input  logic signed [sbg_pkg::SAMPLE_BITS-1:0]    bin_real,
	input  logic signed [sbg_pkg::SAMPLE_BITS-1:0]    bin_imag,
	input  logic signed [sbg_pkg::LIMIT_W-1:0]        lower_limit_db,
	input  logic signed [sbg_pkg::LIMIT_W-1:0]        upper_limit_db,
	output logic                                      result_valid,
	output logic signed [sbg_pkg::SAMPLE_BITS-1:0]    out_real,
	output logic signed [sbg_pkg::SAMPLE_BITS-1:0]    out_imag,
	output logic                                      was_gated,
	input  logic                                      cfg_write,
	input  logic [sbg_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [sbg_pkg::CFG_DATA_W-1:0]            cfg_data
);

	localparam int SW = sbg_pkg::SAMPLE_BITS;
	localparam int LW = sbg_pkg::LIMIT_W;
	localparam int PW = sbg_pkg::PWR_W;
	localparam int NW = sbg_pkg::POS_W;

	// config registers
	logic                 gate_enable_q;
	logic signed [LW-1:0] level_adjust_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_enable_q  <= 1'b0;
			level_adjust_q <= sbg_pkg::ADJUST_RESET;
		end else if (cfg_write) begin
			case (sbg_pkg::cfg_index_t'(cfg_index))
				sbg_pkg::CFG_GATE_ENABLE:  gate_enable_q  <= cfg_data[0];
				sbg_pkg::CFG_LEVEL_ADJUST: level_adjust_q <= signed'(cfg_data[LW-1:0]);
				default: ;
			endcase
		end
	end

	// accept stage
	logic accept;
	logic in_range;
	logic is_process;
	logic [sbg_pkg::ADDR_W-1:0] addr;

	assign busy       = 1'b0;
	assign accept     = start && !busy;
	assign in_range   = 32'(bin_index) < 32'(sbg_pkg::BIN_COUNT);
	assign is_process = sbg_pkg::opcode_t'(opcode) == sbg_pkg::OP_PROCESS;
	assign addr       = sbg_pkg::ADDR_W'(bin_index);

	// limit tables with a registered read; a write and a later read of the
	// same bin are always on different edges, so no forwarding is needed
	logic signed [LW-1:0] lower_mem [sbg_pkg::BIN_COUNT];
	logic signed [LW-1:0] upper_mem [sbg_pkg::BIN_COUNT];
	logic signed [LW-1:0] lo_rd_s1;
	logic signed [LW-1:0] hi_rd_s1;

	always_ff @(posedge clk) begin
		if (accept && !is_process && in_range) begin
			lower_mem[addr] <= lower_limit_db;
			upper_mem[addr] <= upper_limit_db;
		end
		if (accept && is_process) begin
			lo_rd_s1 <= lower_mem[addr];
			hi_rd_s1 <= upper_mem[addr];
		end
	end

	// stage 1: registered command
	logic          vld_s1;
	logic          chk_s1;
	logic          dc_s1;
	logic signed [SW-1:0] re_s1;
	logic signed [SW-1:0] im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept && is_process;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chk_s1 <= gate_enable_q && in_range;
			dc_s1  <= bin_index == '0;
			re_s1  <= bin_real;
			im_s1  <= bin_imag;
		end
	end

	// magnitudes; the most negative sample maps to 2^(SW-1), still in SW bits
	logic [SW-1:0] mag_re;
	logic [SW-1:0] mag_im;

	assign mag_re = re_s1[SW-1] ? SW'(-re_s1) : SW'(re_s1);
	assign mag_im = dc_s1 ? '0 : (im_s1[SW-1] ? SW'(-im_s1) : SW'(im_s1));

	// stage 2: squares
	logic                   vld_s2;
	sbg_pkg::carry_t        car_s2;
	logic [PW-1:0]          sq_re_s2;
	logic [PW-1:0]          sq_im_s2;

	// later stages
	logic                   vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	sbg_pkg::carry_t        car_s3, car_s4, car_s5, car_s6, car_s7;
	logic [PW-1:0]          pwr_s3;
	logic [PW-1:0]          pwr_s4;
	logic [NW-1:0]          pos_s4;
	logic                   nz_s4, nz_s5, nz_s6;
	logic [sbg_pkg::LIN_W-1:0]  lin_s5;
	logic [sbg_pkg::PROD_W-1:0] prod_s6;
	logic signed [LW-1:0]   db_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// leading one position over the power word
	function automatic logic [NW-1:0] lead_one(input logic [PW-1:0] v);
		logic [NW-1:0] pos;
		pos = '0;
		for (int i = 0; i < PW; i++) begin
			if (v[i]) pos = NW'(i);
		end
		return pos;
	endfunction

	// fraction index: the FRAC_W bits under the leading one, zero padded
	logic [PW+sbg_pkg::FRAC_W-1:0] frac_sh;
	logic [sbg_pkg::FRAC_W-1:0]    frac_idx;
	logic [sbg_pkg::LIN_W-1:0]     lin_d;

	assign frac_sh  = {pwr_s4, {sbg_pkg::FRAC_W{1'b0}}} >> pos_s4;
	assign frac_idx = frac_sh[sbg_pkg::FRAC_W-1:0];
	assign lin_d    = {pos_s4, 8'd0} + sbg_pkg::LIN_W'(sbg_pkg::LOG2_FRAC[frac_idx]);

	// scale to q8.8 dB with rounding, remove full scale, saturate
	logic [sbg_pkg::PROD_W:0]  rnd_sum;
	logic [sbg_pkg::PROD_W-16:0] scaled;
	logic signed [sbg_pkg::PROD_W-14:0] db_wide;
	logic signed [LW-1:0]      db_sat;

	assign rnd_sum = {1'b0, prod_s6} + (sbg_pkg::PROD_W+1)'(32768);
	assign scaled  = rnd_sum[sbg_pkg::PROD_W:16];
	assign db_wide = signed'({1'b0, scaled}) - (sbg_pkg::PROD_W-13)'(sbg_pkg::DB_OFFSET);

	always_comb begin
		if (!nz_s6) begin
			db_sat = {1'b1, {(LW-1){1'b0}}};
		end else if (db_wide < signed'((sbg_pkg::PROD_W-13)'(-32768))) begin
			db_sat = {1'b1, {(LW-1){1'b0}}};
		end else if (db_wide > signed'((sbg_pkg::PROD_W-13)'(32767))) begin
			db_sat = {1'b0, {(LW-1){1'b1}}};
		end else begin
			db_sat = LW'(db_wide);
		end
	end

	always_ff @(posedge clk) begin
		// stage 2
		car_s2.chk <= chk_s1;
		car_s2.re  <= re_s1;
		car_s2.im  <= im_s1;
		car_s2.lo  <= lo_rd_s1;
		car_s2.hi  <= hi_rd_s1;
		sq_re_s2   <= PW'(mag_re) * PW'(mag_re);
		sq_im_s2   <= PW'(mag_im) * PW'(mag_im);
		// stage 3: power, cannot exceed 2^(PW-1)
		car_s3 <= car_s2;
		pwr_s3 <= sq_re_s2 + sq_im_s2;
		// stage 4: leading one
		car_s4 <= car_s3;
		pwr_s4 <= pwr_s3;
		pos_s4 <= lead_one(pwr_s3);
		nz_s4  <= pwr_s3 != '0;
		// stage 5: log2 in q.8
		car_s5 <= car_s4;
		lin_s5 <= lin_d;
		nz_s5  <= nz_s4;
		// stage 6: times 10*log10(2) in q16
		car_s6  <= car_s5;
		prod_s6 <= sbg_pkg::PROD_W'(lin_s5) * sbg_pkg::PROD_W'(sbg_pkg::DB_PER_LOG2_Q16);
		nz_s6   <= nz_s5;
		// stage 7: dB level before adjust
		car_s7 <= car_s6;
		db_s7  <= db_sat;
	end

	// output stage: adjust at full precision and compare against the limits
	logic signed [LW:0] level;
	logic               gate_hit;

	assign level    = (LW+1)'(db_s7) + (LW+1)'(level_adjust_q);
	assign gate_hit = car_s7.chk && ((level < (LW+1)'(car_s7.lo))
		|| (level > (LW+1)'(car_s7.hi)));

	logic                 result_valid_q;
	logic signed [SW-1:0] out_real_q;
	logic signed [SW-1:0] out_imag_q;
	logic                 was_gated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		out_real_q  <= gate_hit ? '0 : car_s7.re;
		out_imag_q  <= gate_hit ? '0 : car_s7.im;
		was_gated_q <= gate_hit;
	end

	assign result_valid = result_valid_q;
	assign out_real     = out_real_q;
	assign out_imag     = out_imag_q;
	assign was_gated    = was_gated_q;

endmodule

@@ dv/spectral_bin_gate_top_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for spectral_bin_gate_top: per-bin dB gating checked
// against an in-bench level predictor; depends on sbg_pkg and the rtl top level
module spectral_bin_gate_top_test;
	import sbg_pkg::*;

	localparam longint DB_PER_OCTAVE_Q16 = 197283;   // 10*log10(2) in q16
	localparam int     SETTLE_CYCLES     = 12;       // pipeline depth plus margin

	// one gated bin as the result port should show it
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
		logic                          gated;
	} gate_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          opcode;
	logic [BIN_W-1:0]              bin_index;
	logic signed [SAMPLE_BITS-1:0] bin_real;
	logic signed [SAMPLE_BITS-1:0] bin_imag;
	logic signed [LIMIT_W-1:0]     lower_limit_db;
	logic signed [LIMIT_W-1:0]     upper_limit_db;
	logic                          result_valid;
	logic signed [SAMPLE_BITS-1:0] out_real;
	logic signed [SAMPLE_BITS-1:0] out_imag;
	logic                          was_gated;
	logic                          cfg_write;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;

	// predictor copy of the block's registers and limit tables
	logic                      gate_on;
	logic signed [LIMIT_W-1:0] level_adjust;
	logic signed [LIMIT_W-1:0] lower_limit_tbl [BIN_COUNT];
	logic signed [LIMIT_W-1:0] upper_limit_tbl [BIN_COUNT];
	gate_result_t              expected_bins [$];

	// stimulus side bookkeeping: only bins with loaded limits are ever processed
	bit               bin_loaded [BIN_COUNT];
	logic [BIN_W-1:0] loaded_bins [$];
	int               burst_left;

	int fail_count;
	int items_sent;
	int limit_writes;
	int results_checked;
	int gated_seen;
	int reg_writes;

	spectral_bin_gate_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.bin_index      (bin_index),
		.bin_real       (bin_real),
		.bin_imag       (bin_imag),
		.lower_limit_db (lower_limit_db),
		.upper_limit_db (upper_limit_db),
		.result_valid   (result_valid),
		.out_real       (out_real),
		.out_imag       (out_imag),
		.was_gated      (was_gated),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// q8.8 dB level of a bin power, full scale at 0 dB, zero power at -128 dB
	function automatic int bin_level_db(longint unsigned pwr);
		int              msb;
		int              frac_idx;
		longint unsigned lin;
		longint unsigned scaled;
		longint unsigned full_scale;
		longint          db;
		if (pwr == 0)
			return -32768;
		msb = 63;
		while (!pwr[msb])
			msb--;
		// six bits under the leading one index the fraction table
		if (msb >= 6)
			frac_idx = int'((pwr >> (msb - 6)) & 64'd63);
		else
			frac_idx = int'((pwr << (6 - msb)) & 64'd63);
		lin = longint'(msb) * 256 + LOG2_FRAC[frac_idx];
		scaled = (lin * DB_PER_OCTAVE_Q16 + 32768) >> 16;
		full_scale = (longint'(2 * (SAMPLE_BITS - 1)) * 256 * DB_PER_OCTAVE_Q16 + 32768) >> 16;
		db = longint'(scaled) - longint'(full_scale);
		if (db < -32768)
			db = -32768;
		if (db > 32767)
			db = 32767;
		return int'(db);
	endfunction

	// expected result of a process transaction under the current predictor state
	function automatic gate_result_t gate_bin(logic [BIN_W-1:0] bin,
			logic signed [SAMPLE_BITS-1:0] re, logic signed [SAMPLE_BITS-1:0] im);
		gate_result_t    r;
		longint unsigned pwr;
		int              level;
		r.re = re;
		r.im = im;
		r.gated = 1'b0;
		if (gate_on && bin < BIN_COUNT) begin
			pwr = longint'(re) * longint'(re);
			// dc bin: imaginary part stays out of the power
			if (bin != 0)
				pwr += longint'(im) * longint'(im);
			// level keeps 17 bits, no saturation after the adjust
			level = bin_level_db(pwr) + int'(level_adjust);
			if (level < int'(lower_limit_tbl[bin]) || level > int'(upper_limit_tbl[bin])) begin
				r.re = '0;
				r.im = '0;
				r.gated = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic flag_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// single observer: checks each result strobe, then tracks accepted
	// transactions and register writes into the predictor
	always @(posedge clk) begin : observe
		gate_result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_bins.size() == 0) begin
					flag_failure($sformatf("result with none expected: re %0d im %0d gated %0b",
						out_real, out_imag, was_gated));
				end else begin
					want = expected_bins.pop_front();
					results_checked++;
					if (was_gated === 1'b1)
						gated_seen++;
					if (out_real !== want.re || out_imag !== want.im || was_gated !== want.gated)
						flag_failure($sformatf(
							"expected re %0d im %0d gated %0b, got re %0d im %0d gated %0b",
							want.re, want.im, want.gated, out_real, out_imag, was_gated));
				end
			end
			if (cfg_write) begin
				case (cfg_index_t'(cfg_index))
					CFG_GATE_ENABLE:  gate_on = cfg_data[0];
					CFG_LEVEL_ADJUST: level_adjust = $signed(cfg_data);
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (opcode == OP_WRITE) begin
					// writes land whatever the enable holds, and give no result
					if (bin_index < BIN_COUNT) begin
						lower_limit_tbl[bin_index] = lower_limit_db;
						upper_limit_tbl[bin_index] = upper_limit_db;
					end
				end else begin
					expected_bins = {expected_bins, gate_bin(bin_index, bin_real, bin_imag)};
				end
			end
		end
	end

	// idle cycles before the next transaction; now and then a burst with none
	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	// random bin component across all magnitudes, zero now and then
	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
		if ($urandom_range(0, 15) == 0)
			return '0;
		return SAMPLE_BITS'($signed($urandom) >>> (8 + $urandom_range(0, 23)));
	endfunction

	function automatic logic signed [LIMIT_W-1:0] clamp_q88(int v);
		if (v < -32768)
			return -16'sd32768;
		if (v > 32767)
			return 16'sd32767;
		return LIMIT_W'(v);
	endfunction

	// drive one command transaction and hold it until accepted; start stays
	// high on return so that a back-to-back transaction needs no second update
	task automatic send_item(opcode_t op, logic [BIN_W-1:0] bin,
			logic signed [SAMPLE_BITS-1:0] re, logic signed [SAMPLE_BITS-1:0] im,
			logic signed [LIMIT_W-1:0] lo, logic signed [LIMIT_W-1:0] hi);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		opcode         <= op;
		bin_index      <= bin;
		bin_real       <= re;
		bin_imag       <= im;
		lower_limit_db <= lo;
		upper_limit_db <= hi;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// limit write; the sample fields carry random don't-care values
	task automatic write_limits(logic [BIN_W-1:0] bin, logic signed [LIMIT_W-1:0] lo,
			logic signed [LIMIT_W-1:0] hi);
		send_item(OP_WRITE, bin, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), lo, hi);
		limit_writes++;
		if (!bin_loaded[bin]) begin
			bin_loaded[bin] = 1'b1;
			loaded_bins = {loaded_bins, bin};
		end
	endtask

	// process transaction; the limit fields carry random don't-care values
	task automatic process_bin(logic [BIN_W-1:0] bin, logic signed [SAMPLE_BITS-1:0] re,
			logic signed [SAMPLE_BITS-1:0] im);
		send_item(OP_PROCESS, bin, re, im, LIMIT_W'($urandom), LIMIT_W'($urandom));
	endtask

	// register write only with the pipeline drained
	task automatic load_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
		start <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		reg_writes++;
	endtask

	// reset state: gating off, so even full-scale bins pass untouched
	task automatic test_bypass_after_reset();
		write_limits(9'd0, -16'sd32768, 16'sd32767);
		write_limits(9'd511, 16'sd32767, -16'sd32768);
		write_limits(9'd1, LIMIT_W'($urandom), LIMIT_W'($urandom));
		process_bin(9'd511, -24'sd8388608, 24'sd8388607);
		process_bin(9'd0, 24'sd8388607, -24'sd8388608);
		process_bin(9'd1, 24'sd0, 24'sd0);
	endtask

	// enable gating with the reset adjust still in place and probe the limit
	// compares right at, just above and just below a known level
	task automatic test_reset_adjust();
		int probe;
		load_register(CFG_GATE_ENABLE, 16'hFFFF);
		probe = bin_level_db(64'd1 << 44) + int'(level_adjust);
		write_limits(9'd2, clamp_q88(probe), clamp_q88(probe));
		process_bin(9'd2, 24'sh400000, 24'sd0);
		write_limits(9'd3, clamp_q88(probe + 1), 16'sd32767);
		process_bin(9'd3, 24'sh400000, 24'sd0);
		write_limits(9'd4, -16'sd32768, clamp_q88(probe - 1));
		process_bin(9'd4, 24'sh400000, 24'sd0);
	endtask

	// zero power, dc bin, inverted limits and both adjust extremes
	task automatic test_gate_extremes();
		process_bin(9'd0, 24'sd0, 24'sd8388607);          // dc, zero power: gated
		process_bin(9'd0, -24'sd8388608, -24'sd8388608);  // dc at 0 dB, im passes
		process_bin(9'd511, 24'sd8388607, 24'sd8388607);  // lower above upper
		write_limits(9'd5, -16'sd32768, 16'sd32767);
		process_bin(9'd5, -24'sd8388608, -24'sd8388608);
		load_register(CFG_LEVEL_ADJUST, 16'h7FFF);
		process_bin(9'd5, -24'sd8388608, -24'sd8388608);  // level past 16 bits
		process_bin(9'd5, 24'sd1, 24'sd0);
		load_register(CFG_LEVEL_ADJUST, 16'h8000);
		process_bin(9'd5, 24'sd1, -24'sd1);
		process_bin(9'd5, -24'sd8388608, 24'sd0);         // level equals the floor
	endtask

	// phases of random traffic, each under its own enable and adjust setting
	task automatic test_random_traffic();
		int               adj;
		int               guess;
		int               lo;
		int               hi;
		logic             en;
		logic [BIN_W-1:0] bin;
		for (int phase = 0; phase < 8; phase++) begin
			en = (phase != 2 && phase != 5);
			load_register(CFG_GATE_ENABLE, {15'($urandom), en});
			case (phase)
				0:       adj = -32768;
				1:       adj = 32767;
				3:       adj = -9472;
				default: adj = int'($urandom_range(0, 30000)) - 20000;
			endcase
			load_register(CFG_LEVEL_ADJUST, 16'(adj));
			repeat (128) begin
				if (loaded_bins.size() < 8 || $urandom_range(0, 3) == 0) begin
					bin = BIN_W'($urandom);
					if ($urandom_range(0, 4) == 0) begin
						lo = int'($signed(16'($urandom)));
						hi = int'($signed(16'($urandom)));
					end else begin
						// window around the levels that random samples tend to reach
						guess = adj + int'($urandom_range(0, 14000)) - 15000;
						lo = guess - int'($urandom_range(0, 5000));
						hi = guess + int'($urandom_range(0, 5000));
					end
					write_limits(bin, clamp_q88(lo), clamp_q88(hi));
				end else begin
					if ($urandom_range(0, 7) == 0)
						bin = '0;
					else
						bin = loaded_bins[$urandom_range(0, loaded_bins.size() - 1)];
					process_bin(bin, draw_sample(), draw_sample());
				end
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		start          <= 1'b0;
		opcode         <= OP_WRITE;
		bin_index      <= '0;
		bin_real       <= '0;
		bin_imag       <= '0;
		lower_limit_db <= '0;
		upper_limit_db <= '0;
		cfg_write      <= 1'b0;
		cfg_index      <= CFG_GATE_ENABLE;
		cfg_data       <= '0;
		gate_on        = 1'b0;
		level_adjust   = -16'sd9472;
		burst_left     = 0;
		fail_count     = 0;
		items_sent     = 0;
		limit_writes   = 0;
		results_checked = 0;
		gated_seen     = 0;
		reg_writes     = 0;
		foreach (lower_limit_tbl[i]) begin
			lower_limit_tbl[i] = '0;
			upper_limit_tbl[i] = '0;
			bin_loaded[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass_after_reset();
		test_reset_adjust();
		test_gate_extremes();
		test_random_traffic();

		// drain the pipeline, then give stray strobes time to show up
		start <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d transactions (%0d limit writes) and %0d register writes",
			items_sent, limit_writes, reg_writes);
		$display("checked %0d results, %0d of them gated; %0d failures",
			results_checked, gated_seen, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hang guard, far above the slowest legal run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
